FILE: hw/rtl/lbh_pkg.sv
`default_nettype none

package lbh_pkg;

  // histogram geometry
  localparam int MaxBins    = 63;
  localparam int NumBuckets = MaxBins + 1;
  localparam int BinW       = $clog2(NumBuckets);
  localparam int StepW      = $clog2(BinW);

  // field widths
  localparam int SampleW = 32;
  localparam int WidthW  = 31;
  localparam int CntW    = 32;
  localparam int CumW    = 39;
  localparam int BndW    = 38;
  localparam int SumW    = 64;
  // internal bound arithmetic, wide enough for bin_min + bin_width * MaxBins
  localparam int ThrW    = 40;

  // request codes
  localparam logic [1:0] ReqObserve = 2'd0;
  localparam logic [1:0] ReqCollect = 2'd1;
  localparam logic [1:0] ReqClear   = 2'd2;

  // response codes
  localparam logic [1:0] RespObsAck = 2'd0;
  localparam logic [1:0] RespBucket = 2'd1;
  localparam logic [1:0] RespClrAck = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CfgBinMin   = 2'd0;
  localparam logic [1:0] CfgBinWidth = 2'd1;
  localparam logic [1:0] CfgNumBins  = 2'd2;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [SampleW-1:0] sample;
  } lbh_in_t;

  typedef struct packed {
    logic [1:0]      resp_kind;
    logic [BinW-1:0] bucket_index;
    logic [CumW-1:0] cum_cnt;
    logic [BndW-1:0] upper_bnd;
    logic            upper_is_infinite;
    logic [SumW-1:0] smp_sum;
    logic            last;
  } lbh_out_t;

  // count memory access
  typedef struct packed {
    logic            rd_en;
    logic [BinW-1:0] rd_addr;
    logic            wr_en;
    logic [BinW-1:0] wr_addr;
    logic [CntW-1:0] wr_data;
    logic            clr;
  } lbh_mem_req_t;

  // bucket search result
  typedef struct packed {
    logic            done;
    logic [BinW-1:0] bin;
    logic [BndW-1:0] bound;
    logic            inf;
  } lbh_srch_sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/lbh_count_mem.sv
`default_nettype none

module lbh_count_mem (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  lbh_pkg::lbh_mem_req_t     req_i,
  output logic [lbh_pkg::CntW-1:0]  rd_cnt_o
);
  import lbh_pkg::*;

  logic [CntW-1:0]       cnt_mem_q [NumBuckets];
  logic [CntW-1:0]       rd_data_q;
  logic [NumBuckets-1:0] vld_q;
  logic                  rd_vld_q;

  // count storage, one read and one write port
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      cnt_mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= cnt_mem_q[req_i.rd_addr];
    end
  end

  // per-entry written flags, an entry never written reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.clr) begin
        vld_q <= '0;
      end else if (req_i.wr_en) begin
        vld_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_vld_q <= vld_q[req_i.rd_addr];
      end
    end
  end

  assign rd_cnt_o = rd_vld_q ? rd_data_q : '0;

endmodule

`default_nettype wire

FILE: hw/rtl/lbh_bin_search.sv
`default_nettype none

module lbh_bin_search (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [lbh_pkg::SampleW-1:0] sample_i,
  input  logic [lbh_pkg::SampleW-1:0] bin_min_i,
  input  logic [lbh_pkg::WidthW-1:0]  bin_width_i,
  input  logic [lbh_pkg::BinW-1:0]    nbins_i,
  output lbh_pkg::lbh_srch_sts_t      sts_o
);
  import lbh_pkg::*;

  logic                   busy_q;
  logic                   done_q;
  logic [StepW-1:0]       step_q;
  logic [BinW-1:0]        acc_q;
  logic signed [ThrW-1:0] thr_q;

  logic signed [ThrW-1:0] width_ext;
  logic signed [ThrW-1:0] min_ext;
  logic signed [ThrW-1:0] sample_ext;
  logic signed [ThrW-1:0] trial_val;
  logic signed [ThrW-1:0] bnd_sum;
  logic [BinW-1:0]        trial_idx;
  logic                   take;

  assign width_ext  = {{(ThrW-WidthW){1'b0}}, bin_width_i};
  assign min_ext    = {{(ThrW-SampleW){bin_min_i[SampleW-1]}}, bin_min_i};
  assign sample_ext = {{(ThrW-SampleW){sample_i[SampleW-1]}}, sample_i};

  // thr_q holds the bound of bucket acc_q-1; try raising acc_q by one bit
  assign trial_idx = acc_q | (BinW'(1) << step_q);
  assign trial_val = thr_q + (width_ext << step_q);
  assign take      = (trial_idx <= nbins_i) && (trial_val < sample_ext);

  // search control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= busy_q && (step_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= StepW'(BinW - 1);
      end else if (busy_q) begin
        if (step_q == '0) begin
          busy_q <= 1'b0;
        end else begin
          step_q <= step_q - 1'b1;
        end
      end
    end
  end

  // count of in-use buckets whose bound is below the sample, one bit a step
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      thr_q <= min_ext - width_ext;
    end else if (busy_q && take) begin
      acc_q <= trial_idx;
      thr_q <= trial_val;
    end
  end

  assign bnd_sum = thr_q + width_ext;

  always_comb begin
    sts_o.done  = done_q;
    sts_o.bin   = acc_q;
    sts_o.bound = bnd_sum[BndW-1:0];
    sts_o.inf   = (acc_q == nbins_i);
  end

endmodule

`default_nettype wire

FILE: hw/rtl/linear_bucket_histogram.sv
`default_nettype none
// observe: these steps run in order, then the block returns to idle and takes the next request
// (6-step bucket search, latch of the bucket, one count read, one write back with the result)
// collect: a count read and a line for each bucket in turn, num_bins+1 lines, none taken until the last
// clear: the ack is sent from the clear state, then the next request is taken; output stalls hold every reply
// reset loads register defaults and marks all counts zero at once through per-bucket flags

module linear_bucket_histogram (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [lbh_pkg::SampleW-1:0] cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  lbh_pkg::lbh_in_t            in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output lbh_pkg::lbh_out_t           out_data_o
);
  import lbh_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SRCH  = 7'b0000010,
    ST_OUPD  = 7'b0000100,
    ST_CRD   = 7'b0001000,
    ST_CEMIT = 7'b0010000,
    ST_CLR   = 7'b0100000,
    ST_ORD   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [SampleW-1:0] bin_min_q;
  logic [WidthW-1:0]  bin_width_q;
  logic [BinW-1:0]    num_bins_q;
  logic [BinW-1:0]    nb;

  logic [SampleW-1:0] sample_q;
  logic [SumW-1:0]    sum_q, sum_d;
  logic [BinW-1:0]    idx_q, idx_d;
  logic [CumW-1:0]    cum_q, cum_d;
  logic signed [ThrW-1:0] bnd_q, bnd_d;
  logic               inf_q, inf_d;

  logic               out_valid_q, out_valid_d;
  lbh_out_t           out_q, out_d;
  logic               emit;
  logic               out_free;

  logic               in_acc;
  logic               srch_start;
  lbh_srch_sts_t      srch_sts;
  lbh_mem_req_t       mem_req;
  logic [CntW-1:0]    rd_cnt;

  logic [CntW-1:0]    new_cnt;
  logic [SumW:0]      sum_ext;
  logic [SumW-1:0]    sum_sat;
  logic [CumW:0]      cum_sum;
  logic [CumW-1:0]    cum_new;
  logic signed [ThrW-1:0] width_ext;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_min_q   <= '0;
      bin_width_q <= WidthW'(65536);
      num_bins_q  <= BinW'(MaxBins);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgBinMin:   bin_min_q   <= cfg_wdata_i;
        CfgBinWidth: bin_width_q <= cfg_wdata_i[WidthW-1:0];
        CfgNumBins:  num_bins_q  <= cfg_wdata_i[BinW-1:0];
        default: ;
      endcase
    end
  end

  assign nb        = (num_bins_q > BinW'(MaxBins)) ? BinW'(MaxBins) : num_bins_q;
  assign width_ext = {{(ThrW-WidthW){1'b0}}, bin_width_q};

  // input handshake
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign srch_start = in_acc && (in_data_i.req_type == ReqObserve);
  assign out_free   = !out_valid_q || !out_stall_i;

  lbh_bin_search u_search (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (srch_start),
    .sample_i    (sample_q),
    .bin_min_i   (bin_min_q),
    .bin_width_i (bin_width_q),
    .nbins_i     (nb),
    .sts_o       (srch_sts)
  );

  lbh_count_mem u_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (mem_req),
    .rd_cnt_o (rd_cnt)
  );

  // saturating count increment and sample sum
  assign new_cnt = (rd_cnt == '1) ? rd_cnt : rd_cnt + 1'b1;
  assign sum_ext = {sum_q[SumW-1], sum_q} +
                   {{(SumW+1-SampleW){sample_q[SampleW-1]}}, sample_q};
  always_comb begin
    if (sum_ext[SumW] != sum_ext[SumW-1]) begin
      sum_sat = sum_ext[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
    end else begin
      sum_sat = sum_ext[SumW-1:0];
    end
  end

  // saturating cumulative count
  assign cum_sum = {1'b0, cum_q} + {{(CumW+1-CntW){1'b0}}, rd_cnt};
  assign cum_new = cum_sum[CumW] ? '1 : cum_sum[CumW-1:0];

  // sequencer
  always_comb begin
    state_d = state_q;
    sum_d   = sum_q;
    idx_d   = idx_q;
    cum_d   = cum_q;
    bnd_d   = bnd_q;
    inf_d   = inf_q;
    emit    = 1'b0;
    out_d   = '0;
    mem_req = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_data_i.req_type)
            ReqObserve: state_d = ST_SRCH;
            ReqCollect: begin
              idx_d   = '0;
              cum_d   = '0;
              bnd_d   = {{(ThrW-SampleW){bin_min_q[SampleW-1]}}, bin_min_q};
              state_d = ST_CRD;
            end
            ReqClear: state_d = ST_CLR;
            default: ;
          endcase
        end
      end
      ST_SRCH: begin
        if (srch_sts.done) begin
          idx_d   = srch_sts.bin;
          inf_d   = srch_sts.inf;
          bnd_d   = {{(ThrW-BndW){srch_sts.bound[BndW-1]}}, srch_sts.bound};
          state_d = ST_ORD;
        end
      end
      ST_ORD: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = idx_q;
        state_d         = ST_OUPD;
      end
      ST_OUPD: begin
        if (out_free) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = idx_q;
          mem_req.wr_data = new_cnt;
          sum_d           = sum_sat;
          emit            = 1'b1;
          out_d.resp_kind         = RespObsAck;
          out_d.bucket_index      = idx_q;
          out_d.cum_cnt           = {{(CumW-CntW){1'b0}}, new_cnt};
          out_d.upper_bnd         = inf_q ? '0 : bnd_q[BndW-1:0];
          out_d.upper_is_infinite = inf_q;
          out_d.smp_sum           = sum_sat;
          out_d.last              = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_CRD: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = idx_q;
        state_d         = ST_CEMIT;
      end
      ST_CEMIT: begin
        if (out_free) begin
          emit  = 1'b1;
          cum_d = cum_new;
          out_d.resp_kind         = RespBucket;
          out_d.bucket_index      = idx_q;
          out_d.cum_cnt           = cum_new;
          out_d.upper_bnd         = (idx_q == nb) ? '0 : bnd_q[BndW-1:0];
          out_d.upper_is_infinite = (idx_q == nb);
          out_d.smp_sum           = sum_q;
          out_d.last              = (idx_q == nb);
          if (idx_q == nb) begin
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_q + 1'b1;
            bnd_d   = bnd_q + width_ext;
            state_d = ST_CRD;
          end
        end
      end
      ST_CLR: begin
        if (out_free) begin
          mem_req.clr     = 1'b1;
          sum_d           = '0;
          emit            = 1'b1;
          out_d.resp_kind = RespClrAck;
          out_d.last      = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // output register
  assign out_valid_d = emit || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      sum_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      sum_q       <= sum_d;
    end
  end

  // request payload and walk registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sample_q <= in_data_i.sample;
    end
    if (emit) begin
      out_q <= out_d;
    end
    idx_q <= idx_d;
    cum_q <= cum_d;
    bnd_q <= bnd_d;
    inf_q <= inf_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

FILE: sim/linear_bucket_histogram_tb.sv
`timescale 1ns / 100ps

module linear_bucket_histogram_tb;
  import lbh_pkg::*;

  localparam int ResetCycles  = 8;
  localparam int SettleCycles = 16;
  localparam int TimeoutNs    = 10_000_000;

  // request code the block must ignore, register index with no register behind it
  localparam logic [1:0] ReqUnknown = 2'd3;
  localparam logic [1:0] CfgUnused  = 2'd3;

  localparam logic [63:0] CumLimit = (64'd1 << CumW) - 64'd1;
  localparam logic [63:0] SumMax   = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SumMin   = 64'h8000_0000_0000_0000;

  typedef enum int unsigned {StallNone, StallSparse, StallLong} stall_mode_e;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic [1:0]         cfg_idx_i   = CfgBinMin;
  logic [SampleW-1:0] cfg_wdata_i = '0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  lbh_in_t            in_data_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  lbh_out_t           out_data_o;

  // mirror of the block's registers and histogram
  logic signed [SampleW-1:0] mdl_bin_min;
  logic [WidthW-1:0]         mdl_bin_width;
  logic [BinW-1:0]           mdl_num_bins;
  logic [CntW-1:0]           bucket_cnt [NumBuckets];
  logic [SumW-1:0]           sum_acc;

  lbh_out_t    expected_lines [$];
  lbh_out_t    want_line;
  int unsigned mismatch_cnt = 0;
  int unsigned burst_left   = 0;

  stall_mode_e stall_mode = StallNone;
  int unsigned mode_left  = 0;
  int unsigned stall_left = 0;

  linear_bucket_histogram dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // run limit
  initial begin
    #(TimeoutNs);
    $display("RESULT: ERROR");
    $finish;
  end

  // histogram geometry as the block sees it
  function automatic int unsigned bins_active();
    return (int'(mdl_num_bins) > MaxBins) ? MaxBins : int'(mdl_num_bins);
  endfunction

  function automatic longint bucket_bound(int unsigned idx);
    return longint'(mdl_bin_min) + longint'(mdl_bin_width) * longint'(idx);
  endfunction

  function automatic logic [SumW-1:0] sum_sat(logic [SumW-1:0] a, logic [SumW-1:0] b);
    logic [SumW-1:0] t;
    t = a + b;
    if (a[SumW-1] == b[SumW-1] && t[SumW-1] != a[SumW-1]) begin
      return a[SumW-1] ? SumMin : SumMax;
    end
    return t;
  endfunction

  function automatic lbh_out_t make_line(logic [1:0] kind, int unsigned idx, logic [63:0] cum,
                                         bit with_bound, logic [SumW-1:0] sum, bit is_last);
    lbh_out_t line;
    bit       inf;
    inf  = with_bound && (idx >= bins_active());
    line = '0;
    line.resp_kind    = kind;
    line.bucket_index = BinW'(idx);
    line.cum_cnt      = (cum > CumLimit) ? CumLimit[CumW-1:0] : cum[CumW-1:0];
    if (with_bound && !inf) begin
      line.upper_bnd = BndW'(bucket_bound(idx));
    end
    line.upper_is_infinite = inf;
    line.smp_sum           = sum;
    line.last              = is_last;
    return line;
  endfunction

  // append one line to the tail of the expected queue
  task automatic queue_line(lbh_out_t line);
    expected_lines.insert(expected_lines.size(), line);
  endtask

  // histogram update for one accepted request, queues the lines it must produce
  task automatic apply_request(lbh_in_t req);
    int unsigned nb;
    int unsigned bin;
    int unsigned i;
    bit          hit;
    longint      smp;
    logic [63:0] cum;
    nb = bins_active();
    case (req.req_type)
      ReqObserve: begin
        smp = longint'($signed(req.sample));
        bin = nb;
        hit = 1'b0;
        for (i = 0; i < nb; i++) begin
          if (!hit && bucket_bound(i) >= smp) begin
            bin = i;
            hit = 1'b1;
          end
        end
        if (bucket_cnt[bin] != '1) begin
          bucket_cnt[bin] = bucket_cnt[bin] + 1'b1;
        end
        sum_acc = sum_sat(sum_acc, 64'(smp));
        queue_line(make_line(RespObsAck, bin, 64'(bucket_cnt[bin]), 1'b1, sum_acc, 1'b1));
      end
      ReqCollect: begin
        cum = '0;
        for (i = 0; i <= nb; i++) begin
          cum = cum + 64'(bucket_cnt[i]);
          if (cum > CumLimit) begin
            cum = CumLimit;
          end
          queue_line(make_line(RespBucket, i, cum, 1'b1, sum_acc, i == nb));
        end
      end
      ReqClear: begin
        foreach (bucket_cnt[k]) bucket_cnt[k] = '0;
        sum_acc = '0;
        queue_line(make_line(RespClrAck, 0, '0, 1'b0, '0, 1'b1));
      end
      default: ;
    endcase
  endtask

  function automatic lbh_in_t mk_req(logic [1:0] kind, logic [SampleW-1:0] smp);
    lbh_in_t req;
    req.req_type = kind;
    req.sample   = smp;
    return req;
  endfunction

  // one input transaction, sent in bursts with random gaps in between
  task automatic send_request(lbh_in_t req);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    apply_request(req);
    burst_left--;
  endtask

  // stop sending and wait until every queued line has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (expected_lines.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // write enable stays high, the caller lowers it after the last write
  task automatic write_reg(logic [1:0] idx, logic [SampleW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      CfgBinMin:   mdl_bin_min   = data;
      CfgBinWidth: mdl_bin_width = data[WidthW-1:0];
      CfgNumBins:  mdl_num_bins  = data[BinW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [SampleW-1:0] lo, logic [SampleW-1:0] wd,
                            logic [SampleW-1:0] nbv);
    drain();
    write_reg(CfgBinMin, lo);
    write_reg(CfgBinWidth, wd);
    write_reg(CfgNumBins, nbv);
    cfg_we_i <= 1'b0;
  endtask

  // random request; most observe samples sit near a bucket bound or within a bin width below it, the rest anywhere
  function automatic lbh_in_t random_request();
    lbh_in_t     req;
    int unsigned pick;
    longint      target;
    pick       = $urandom_range(0, 99);
    req.sample = $urandom;
    if (pick < 75) req.req_type = ReqObserve;
    else if (pick < 88) req.req_type = ReqCollect;
    else if (pick < 93) req.req_type = ReqClear;
    else req.req_type = ReqUnknown;
    if (req.req_type == ReqObserve && $urandom_range(0, 3) != 0) begin
      target = bucket_bound($urandom_range(0, bins_active()));
      if ($urandom_range(0, 1) == 0) target = target + longint'($urandom_range(0, 4)) - 2;
      else target = target - longint'($urandom_range(0, mdl_bin_width));
      if (target >= -64'sh8000_0000 && target <= 64'sh7FFF_FFFF) begin
        req.sample = 32'(target);
      end
    end
    return req;
  endfunction

  task automatic random_config();
    logic [SampleW-1:0] lo;
    logic [SampleW-1:0] wd;
    logic [SampleW-1:0] nbv;
    case ($urandom_range(0, 3))
      0: lo = $urandom;
      1: lo = (32'($urandom_range(0, 80)) << 16) - 32'h0028_0000;
      2: lo = 32'h8000_0000;
      default: lo = 32'h7FFF_FFFF;
    endcase
    case ($urandom_range(0, 5))
      0: wd = $urandom;
      2: wd = 32'd1;
      3: wd = 32'hFFFF_FFFF;
      4: wd = 32'd0;
      default: wd = 32'($urandom_range(1, 8)) << 14;
    endcase
    case ($urandom_range(0, 3))
      0: nbv = $urandom;
      1: nbv = 32'd0;
      2: nbv = 32'd63;
      default: nbv = $urandom_range(1, 8);
    endcase
    set_config(lo, wd, nbv);
  endtask

  // default geometry straight out of reset, bound hits, extremes, ignored code, clear
  task automatic test_reset_state();
    send_request(mk_req(ReqCollect, '0));
    send_request(mk_req(ReqObserve, 32'h0000_0000));
    send_request(mk_req(ReqObserve, 32'h0001_0000));
    send_request(mk_req(ReqObserve, 32'h0001_0001));
    send_request(mk_req(ReqObserve, 32'hFFFF_FFFF));
    send_request(mk_req(ReqObserve, 32'h8000_0000));
    send_request(mk_req(ReqObserve, 32'h7FFF_FFFF));
    send_request(mk_req(ReqUnknown, 32'hFFFF_FFFF));
    send_request(mk_req(ReqCollect, 32'hFFFF_FFFF));
    send_request(mk_req(ReqClear, 32'h5555_AAAA));
    send_request(mk_req(ReqCollect, '0));
    drain();
  endtask

  task automatic test_register_extremes();
    // no finite buckets, only the overflow one
    set_config(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(mk_req(ReqObserve, 32'h7FFF_FFFF));
    send_request(mk_req(ReqObserve, 32'h8000_0000));
    send_request(mk_req(ReqCollect, '0));
    // widest spacing from the lowest bound, bounds run far past 32 bits
    set_config(32'h8000_0000, 32'h7FFF_FFFF, 32'd63);
    send_request(mk_req(ReqObserve, 32'h8000_0000));
    send_request(mk_req(ReqObserve, 32'h7FFF_FFFF));
    send_request(mk_req(ReqCollect, '0));
    // zero width: all finite bounds equal bin_min, upper bits of num_bins dropped
    set_config(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(mk_req(ReqObserve, 32'h0000_0000));
    send_request(mk_req(ReqObserve, 32'h0000_0001));
    send_request(mk_req(ReqObserve, 32'hFFFF_FFFF));
    // write to an index with no register
    drain();
    write_reg(CfgUnused, 32'hDEAD_BEEF);
    cfg_we_i <= 1'b0;
    // shrinking the range hides counts without clearing them
    set_config(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFC2);
    send_request(mk_req(ReqCollect, '0));
    set_config(32'h0000_0000, 32'h0000_0000, 32'd63);
    send_request(mk_req(ReqCollect, '0));
    drain();
  endtask

  task automatic test_random_traffic();
    repeat (5) begin
      random_config();
      repeat (25) send_request(random_request());
    end
  endtask

  // receiver stall pattern: calm stretches, sparse random stalls, long stalls
  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 2));
      mode_left  = $urandom_range(16, 160);
    end else begin
      mode_left--;
    end
    if (stall_left != 0) begin
      stall_left--;
    end else if (stall_mode == StallLong && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 16);
    end
    out_stall_i <= (stall_left != 0) || (stall_mode == StallSparse && $urandom_range(0, 2) == 0);
  end

  task automatic note_mismatch(string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      note_mismatch($sformatf("%s expected %0h got %0h", name, want, got));
    end
  endtask

  // compare each output transaction with the oldest queued line
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_lines.size() == 0) begin
        note_mismatch($sformatf("unexpected result %h", out_data_o));
      end else begin
        want_line = expected_lines.pop_front();
        check_field("resp_kind", want_line.resp_kind, out_data_o.resp_kind);
        check_field("bucket_index", want_line.bucket_index, out_data_o.bucket_index);
        check_field("cum_cnt", want_line.cum_cnt, out_data_o.cum_cnt);
        check_field("upper_bnd", want_line.upper_bnd, out_data_o.upper_bnd);
        check_field("upper_is_infinite", want_line.upper_is_infinite,
                    out_data_o.upper_is_infinite);
        check_field("smp_sum", want_line.smp_sum, out_data_o.smp_sum);
        check_field("last", want_line.last, out_data_o.last);
      end
    end
  end

  initial begin
    // register defaults and an empty histogram, as after reset
    mdl_bin_min   = '0;
    mdl_bin_width = WidthW'(65536);
    mdl_num_bins  = BinW'(MaxBins);
    sum_acc       = '0;
    foreach (bucket_cnt[k]) bucket_cnt[k] = '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_register_extremes();
    test_random_traffic();
    drain();
    if (mismatch_cnt == 0 && expected_lines.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/lbh_pkg.sv
hw/rtl/lbh_count_mem.sv
hw/rtl/lbh_bin_search.sv
hw/rtl/linear_bucket_histogram.sv
sim/linear_bucket_histogram_tb.sv
